[src/crcdf_pkg.sv]
// Shared types, codes and the byte-wise CRC step for the CRC16 frame deframer.
// Used by the deframer core and by its port checker; depends on nothing else.
`timescale 1ns / 1ps

package crcdf_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;

  // Frame verdict codes carried on status when frame_end is set.
  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_LEN_CRC   = 2'd1,
    ST_FRAME_CRC = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_e;

  // One result transaction.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic [1:0] status;
  } result_t;

  // Reflected CCITT CRC (0x8408 form), one byte per call, table-free form.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] e;
    logic [7:0] f;
    e = crc[7:0] ^ b;
    f = e ^ (e << 4);
    return {8'h00, crc[15:8]} ^ {f, 8'h00} ^ {5'b0_0000, f, 3'b000} ^ {12'h000, f[7:4]};
  endfunction

endpackage

[src/crc16_frame_deframer_core.sv]
// CRC16 frame deframer core: header hunt, length check, payload forwarding, frame check.
// Depends on crcdf_pkg for the CRC step, the result type and the status codes.
`timescale 1ns / 1ps

//  Channel   | Handshake                 | Payload
//  ----------+---------------------------+--------------------------------------------------
//  input     | in_valid_i / in_stall_o   | rx_byte_i
//  output    | out_valid_o / out_stall_i | payload_valid_o, payload_byte_o, frame_end_o,
//            |                           | status_o
//  config    | cfg_we_i (no wait)        | cfg_max_payload_len_i
//
// Every received byte produces exactly one result transaction. The byte is decoded in the
// cycle it is accepted and its result is registered into the output or skid register, so the
// block takes one byte per clock for as long as the output side keeps taking results.
// A two-entry output stage (output register plus skid register) parts the two sides:
// a byte is still taken while a result waits, and input stall rises only once the skid
// register is also full. Reset (asynchronous, active low) returns the decoder to header
// hunting, clears both output entries and sets the length limit to 1016.

module crc16_frame_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_max_payload_len_i,
  // Input byte stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // Result stream
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic        frame_end_o,
  output logic [1:0]  status_o
);

  // Decoder phases.
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_LCRC = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_FCRC = 3'd5;

  localparam logic [15:0] MAX_LEN_RESET = 16'd1016;

  logic [15:0] max_len_q;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] byte_count_q, byte_count_d;
  logic [15:0] payload_length_q, payload_length_d;
  logic [15:0] length_crc_q, length_crc_d;
  logic [15:0] frame_crc_q, frame_crc_d;
  logic [7:0]  low_check_q, low_check_d;

  crcdf_pkg::result_t res_d;
  crcdf_pkg::result_t out_q;
  crcdf_pkg::result_t skid_q;
  logic               out_valid_q;
  logic               skid_valid_q;

  logic        in_accept;
  logic        out_take;
  logic [15:0] frame_crc_next;
  logic [15:0] check_word;
  logic [15:0] count_inc;

  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  // Shared CRC step on the running frame CRC and the received check word.
  assign frame_crc_next = crcdf_pkg::crc_byte(frame_crc_q, rx_byte_i);
  assign check_word     = {rx_byte_i, low_check_q};
  assign count_inc      = byte_count_q + 16'd1;

  // The user must write the limit register only while no frame is in flight (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_max_payload_len_i;
    end
  end

  // Per-byte decode: next state and the result for this byte.
  always_comb begin
    phase_d          = phase_q;
    byte_count_d     = byte_count_q;
    payload_length_d = payload_length_q;
    length_crc_d     = length_crc_q;
    frame_crc_d      = frame_crc_q;
    low_check_d      = low_check_q;
    res_d            = '0;
    res_d.status     = crcdf_pkg::ST_GOOD;

    unique case (phase_q)
      PH_HDR2: begin
        // A broken header drops both bytes, even when this byte is another 0xAA.
        if (rx_byte_i == crcdf_pkg::HDR_SECOND) begin
          frame_crc_d  = frame_crc_next;
          length_crc_d = '0;
          byte_count_d = '0;
          phase_d      = PH_LEN;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_LEN: begin
        frame_crc_d  = frame_crc_next;
        length_crc_d = crcdf_pkg::crc_byte(length_crc_q, rx_byte_i);
        if (byte_count_q == 16'd0) begin
          payload_length_d = {8'h00, rx_byte_i};
          byte_count_d     = 16'd1;
        end else begin
          payload_length_d = {rx_byte_i, payload_length_q[7:0]};
          byte_count_d     = '0;
          phase_d          = PH_LCRC;
        end
      end
      PH_LCRC: begin
        frame_crc_d = frame_crc_next;
        if (byte_count_q == 16'd0) begin
          low_check_d  = rx_byte_i;
          byte_count_d = 16'd1;
        end else begin
          byte_count_d = '0;
          if (check_word != length_crc_q) begin
            res_d.frame_end = 1'b1;
            res_d.status    = crcdf_pkg::ST_LEN_CRC;
            phase_d         = PH_HUNT;
          end else if (payload_length_q > max_len_q) begin
            res_d.frame_end = 1'b1;
            res_d.status    = crcdf_pkg::ST_TOO_LONG;
            phase_d         = PH_HUNT;
          end else if (payload_length_q == 16'd0) begin
            // An empty payload goes straight to the frame check word.
            phase_d = PH_FCRC;
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        frame_crc_d          = frame_crc_next;
        res_d.payload_valid  = 1'b1;
        res_d.payload_byte   = rx_byte_i;
        if (count_inc >= payload_length_q) begin
          byte_count_d = '0;
          phase_d      = PH_FCRC;
        end else begin
          byte_count_d = count_inc;
        end
      end
      PH_FCRC: begin
        if (byte_count_q == 16'd0) begin
          low_check_d  = rx_byte_i;
          byte_count_d = 16'd1;
        end else begin
          byte_count_d    = '0;
          res_d.frame_end = 1'b1;
          res_d.status    = (check_word == frame_crc_q) ? crcdf_pkg::ST_GOOD
                                                        : crcdf_pkg::ST_FRAME_CRC;
          phase_d         = PH_HUNT;
        end
      end
      default: begin
        // Hunting; the unused codes behave the same way.
        if (rx_byte_i == crcdf_pkg::HDR_FIRST) begin
          frame_crc_d = crcdf_pkg::crc_byte(16'h0000, rx_byte_i);
          phase_d     = PH_HDR2;
        end else begin
          phase_d = PH_HUNT;
        end
        byte_count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_HUNT;
      byte_count_q     <= '0;
      payload_length_q <= '0;
      length_crc_q     <= '0;
      frame_crc_q      <= '0;
      low_check_q      <= '0;
    end else if (in_accept) begin
      phase_q          <= phase_d;
      byte_count_q     <= byte_count_d;
      payload_length_q <= payload_length_d;
      length_crc_q     <= length_crc_d;
      frame_crc_q      <= frame_crc_d;
      low_check_q      <= low_check_d;
    end
  end

  // Output register with a skid entry behind it. The skid entry fills only when a byte
  // is taken while the output register holds a result that is not being taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (!out_valid_q || out_take) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_valid_o = out_q.payload_valid;
  assign payload_byte_o  = out_q.payload_byte;
  assign frame_end_o     = out_q.frame_end;
  assign status_o        = out_q.status;

endmodule

[src/crcdf_port_checker.sv]
// Port-level checks for the CRC16 frame deframer core, bound into the core module.
// Depends on crcdf_pkg for the status codes.
`timescale 1ns / 1ps

module crcdf_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       payload_valid_o,
  input logic [7:0] payload_byte_o,
  input logic       frame_end_o,
  input logic [1:0] status_o
);

  // A result is either a payload byte or a verdict, never both.
  a_single_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(payload_valid_o && frame_end_o))
    else $error("payload byte and frame verdict in one transaction");

  // Without a verdict the status reads as good.
  a_status_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_end_o) |-> (status_o == crcdf_pkg::ST_GOOD))
    else $error("status set without frame end");

  // A non-payload result carries a zero byte.
  a_byte_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !payload_valid_o) |-> (payload_byte_o == 8'h00))
    else $error("payload byte set without payload valid");

  // The input stalls only after the output side held back a pending result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output backpressure");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(payload_valid_o) && $stable(payload_byte_o) &&
       $stable(frame_end_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind crc16_frame_deframer_core crcdf_port_checker u_crcdf_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .payload_valid_o(payload_valid_o),
  .payload_byte_o (payload_byte_o),
  .frame_end_o    (frame_end_o),
  .status_o       (status_o)
);

[verif/crcdf_tb_pkg.sv]
// Verification helpers for the CRC16 frame deframer: the reset value of the length limit
// and a bit-serial reflected CCITT CRC step. Depends on nothing else.
`timescale 1ns / 1ps

package crcdf_tb_pkg;

  localparam logic [15:0] LEN_LIMIT_RESET = 16'd1016;

  // Reflected polynomial 0x8408, one bit per loop pass, seed chosen by the caller.
  function automatic logic [15:0] kermit16_update(input logic [15:0] crc,
                                                  input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[verif/crc16_frame_deframer_checker.sv]
// Port-level checker for the CRC16 frame deframer: predicts one result per accepted byte
// and compares the result stream against it. Depends on crcdf_pkg and crcdf_tb_pkg.
`timescale 1ns / 1ps

module crc16_frame_deframer_checker
  import crcdf_pkg::*;
  import crcdf_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_max_payload_len_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        payload_valid_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        frame_end_i,
  input  logic [1:0]  status_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HDR2,
    PH_LEN,
    PH_LCRC,
    PH_DATA,
    PH_FCRC
  } rx_phase_e;

  rx_phase_e   phase;
  logic [15:0] byte_count;
  logic [15:0] payload_length;
  logic [15:0] length_crc;
  logic [15:0] frame_crc;
  logic [7:0]  low_check_byte;
  logic [15:0] max_len;

  result_t     predicted_results[$];
  int unsigned mismatches;

  // Advances the frame decoder by one byte and returns the result it must produce.
  task automatic deframe_byte(input logic [7:0] b, output result_t r);
    logic [15:0] rx_check;
    r = '0;
    rx_check = {b, low_check_byte};
    case (phase)
      PH_HDR2: begin
        if (b == HDR_SECOND) begin
          frame_crc  = kermit16_update(frame_crc, b);
          length_crc = 16'h0000;
          byte_count = 16'h0000;
          phase      = PH_LEN;
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_LEN: begin
        frame_crc  = kermit16_update(frame_crc, b);
        length_crc = kermit16_update(length_crc, b);
        if (byte_count == 16'h0000) begin
          payload_length = {8'h00, b};
          byte_count     = 16'd1;
        end else begin
          payload_length[15:8] = b;
          byte_count           = 16'h0000;
          phase                = PH_LCRC;
        end
      end
      PH_LCRC: begin
        frame_crc = kermit16_update(frame_crc, b);
        if (byte_count == 16'h0000) begin
          low_check_byte = b;
          byte_count     = 16'd1;
        end else begin
          byte_count = 16'h0000;
          if (rx_check != length_crc) begin
            r.frame_end = 1'b1;
            r.status    = ST_LEN_CRC;
            phase       = PH_HUNT;
          end else if (payload_length > max_len) begin
            r.frame_end = 1'b1;
            r.status    = ST_TOO_LONG;
            phase       = PH_HUNT;
          end else if (payload_length == 16'h0000) begin
            phase = PH_FCRC;
          end else begin
            phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        frame_crc       = kermit16_update(frame_crc, b);
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        byte_count      = byte_count + 16'd1;
        if (byte_count >= payload_length) begin
          byte_count = 16'h0000;
          phase      = PH_FCRC;
        end
      end
      PH_FCRC: begin
        if (byte_count == 16'h0000) begin
          low_check_byte = b;
          byte_count     = 16'd1;
        end else begin
          byte_count  = 16'h0000;
          r.frame_end = 1'b1;
          r.status    = (rx_check == frame_crc) ? ST_GOOD : ST_FRAME_CRC;
          phase       = PH_HUNT;
        end
      end
      default: begin
        if (b == HDR_FIRST) begin
          frame_crc = kermit16_update(16'h0000, b);
          phase     = PH_HDR2;
        end else begin
          phase = PH_HUNT;
        end
        byte_count = 16'h0000;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t seen;
    if (!rst_ni) begin
      phase          = PH_HUNT;
      byte_count     = 16'h0000;
      payload_length = 16'h0000;
      length_crc     = 16'h0000;
      frame_crc      = 16'h0000;
      low_check_byte = 8'h00;
      max_len        = LEN_LIMIT_RESET;
      mismatches     = 0;
      predicted_results.delete();
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      // Results leave before the byte taken at this same edge is predicted.
      if (out_valid_i && !out_stall_i) begin
        seen = {payload_valid_i, payload_byte_i, frame_end_i, status_i};
        if (predicted_results.size() == 0) begin
          $error("result transaction with no received byte waiting for it");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          compare_field("payload_valid", 8'(want.payload_valid), 8'(seen.payload_valid));
          compare_field("payload_byte", want.payload_byte, seen.payload_byte);
          compare_field("frame_end", 8'(want.frame_end), 8'(seen.frame_end));
          compare_field("status", 8'(want.status), 8'(seen.status));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        deframe_byte(rx_byte_i, want);
        predicted_results.push_back(want);
      end
      if (cfg_we_i) begin
        max_len = cfg_max_payload_len_i;
      end
      mismatch_count_o <= mismatches;
      outstanding_o    <= $unsigned(predicted_results.size());
    end
  end

endmodule

[verif/tb_crc16_frame_deframer_core.sv]
// Testbench top for crc16_frame_deframer_core: drives byte streams of framed and broken
// traffic under random flow control and reports the verdict of the attached checker.
// Depends on crcdf_pkg, crcdf_tb_pkg and crc16_frame_deframer_checker.
`timescale 1ns / 1ps

module tb_crc16_frame_deframer_core;
  import crcdf_pkg::*;
  import crcdf_tb_pkg::*;

  // This bound only catches a hang.
  localparam int unsigned CYCLE_LIMIT       = 1_000_000;
  localparam int unsigned BYTES_PER_SETTING = 300;
  localparam int unsigned SETTING_COUNT     = 5;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_max_len;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        frame_end;
  logic [1:0]  status;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned sent_bytes = 0;

  // Length limit currently programmed, so that frames can be built to pass or fail it.
  logic [15:0] cur_limit = LEN_LIMIT_RESET;
  // When set, the sender offers bytes back to back for the whole frame.
  bit          steady_sender = 1'b0;
  // Payload for the next frame; the caller fills it before send_frame.
  logic [7:0]  payload_q[$];

  crc16_frame_deframer_core u_dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_max_payload_len_i (cfg_max_len),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .rx_byte_i             (rx_byte),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .payload_valid_o       (payload_valid),
    .payload_byte_o        (payload_byte),
    .frame_end_o           (frame_end),
    .status_o              (status)
  );

  crc16_frame_deframer_checker u_checker (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_max_payload_len_i (cfg_max_len),
    .in_valid_i            (in_valid),
    .in_stall_i            (in_stall),
    .rx_byte_i             (rx_byte),
    .out_valid_i           (out_valid),
    .out_stall_i           (out_stall),
    .payload_valid_i       (payload_valid),
    .payload_byte_i        (payload_byte),
    .frame_end_i           (frame_end),
    .status_i              (status),
    .mismatch_count_o      (mismatch_count),
    .outstanding_o         (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake or a result that never arrives.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offers one byte and returns at the edge where the transaction completes. The valid
  // stays high on return, so a caller that stops sending has to lower it at that edge.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    int unsigned sel;
    gap = 0;
    if (!steady_sender) begin
      sel = $urandom_range(0, 99);
      if (sel >= 97) begin
        gap = $urandom_range(10, 40);
      end else if (sel >= 75) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    // The stall seen here is the value from before this edge.
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  // Builds a frame with the given length field and sends it. Once the length is rejected
  // the block is hunting again, so the payload and frame check are only sent when the
  // length passes both its check and the programmed limit.
  task automatic send_frame(input logic [15:0] length_field, input bit bad_len_check,
                            input bit bad_frame_check);
    logic [7:0]  frame[$];
    logic [15:0] check;
    check = kermit16_update(kermit16_update(16'h0000, length_field[7:0]), length_field[15:8]);
    if (bad_len_check) begin
      check ^= 16'($urandom_range(1, 16'hFFFF));
    end
    frame = '{HDR_FIRST, HDR_SECOND, length_field[7:0], length_field[15:8],
              check[7:0], check[15:8]};
    if (!bad_len_check && length_field <= cur_limit) begin
      frame = {frame, payload_q};
      check = 16'h0000;
      foreach (frame[i]) begin
        check = kermit16_update(check, frame[i]);
      end
      if (bad_frame_check) begin
        check ^= 16'($urandom_range(1, 16'hFFFF));
      end
      frame.push_back(check[7:0]);
      frame.push_back(check[15:8]);
    end
    foreach (frame[i]) begin
      send_byte(frame[i]);
    end
  endtask

  // Stops offering bytes and waits until every predicted result has been taken, so that
  // nothing is still in flight inside the block.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side. Mostly short stalls between short open windows, now and then a long open
  // stretch or a longer stall. Once, early in the run, the receiver holds off while the
  // sender keeps going, so the output stage fills up and the block has to stall its input.
  initial begin : result_sink
    int unsigned open_len;
    int unsigned hold_len;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 6);
      repeat (open_len) @(posedge clk);
      if (!long_hold_done && sent_bytes >= 100) begin
        hold_len       = 300;
        long_hold_done = 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        hold_len = $urandom_range(15, 60);
      end else begin
        hold_len = $urandom_range(1, 3);
      end
      out_stall <= 1'b1;
      repeat (hold_len) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin : byte_source
    int unsigned setting;
    int unsigned phase_start;
    int unsigned plen;
    int unsigned kind;
    logic [15:0] next_limit;
    logic [7:0]  stray;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_max_len <= LEN_LIMIT_RESET;
    in_valid    <= 1'b0;
    rx_byte     <= 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed traffic under the reset limit.
    // A broken header: the byte after the first header byte is the first header byte
    // again, and both are dropped.
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    // The largest length field, far above the limit, with a valid length check.
    payload_q.delete();
    send_frame(16'hFFFF, 1'b0, 1'b0);
    // A length whose check bytes are corrupted.
    send_frame(16'd2, 1'b1, 1'b0);
    // A payload at both byte extremes, followed by a wrong frame check.
    payload_q = '{8'hFF, 8'h00};
    send_frame(16'd2, 1'b0, 1'b1);

    // Random traffic, one stretch per limit setting: the reset value, the two extremes,
    // a small limit where too-long frames are common, and a moderate one.
    for (setting = 0; setting < SETTING_COUNT; setting++) begin
      if (setting != 0) begin
        case (setting)
          1:       next_limit = 16'h0000;
          2:       next_limit = 16'hFFFF;
          3:       next_limit = 16'($urandom_range(1, 40));
          default: next_limit = 16'($urandom_range(41, 2000));
        endcase
        // The limit is only changed with the block idle.
        drain_results();
        cfg_we      <= 1'b1;
        cfg_max_len <= next_limit;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit  = next_limit;
      end

      phase_start = sent_bytes;
      while (sent_bytes - phase_start < BYTES_PER_SETTING) begin
        steady_sender = ($urandom_range(0, 3) == 0);
        // Mostly short payloads; a rare longer one.
        plen = ($urandom_range(0, 29) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
        if (plen > cur_limit) begin
          plen = cur_limit;
        end
        payload_q.delete();
        repeat (plen) payload_q.push_back(8'($urandom));

        kind = $urandom_range(0, 99);
        if (kind < 50) begin
          send_frame(16'(plen), 1'b0, 1'b0);
        end else if (kind < 62) begin
          send_frame(16'(plen), 1'b0, 1'b1);
        end else if (kind < 72) begin
          send_frame(16'($urandom), 1'b1, 1'b0);
        end else if (kind < 82 && cur_limit != 16'hFFFF) begin
          send_frame(16'($urandom_range(int'(cur_limit) + 1, 16'hFFFF)), 1'b0, 1'b0);
        end else if (kind < 92) begin
          // A header start followed by anything but the second header byte.
          stray = ($urandom_range(0, 3) == 0) ? HDR_FIRST : 8'($urandom);
          if (stray == HDR_SECOND) begin
            stray = HDR_FIRST;
          end
          send_byte(HDR_FIRST);
          send_byte(stray);
        end else begin
          // Line noise between frames.
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end

        // Occasionally the sender goes quiet until the result side has caught up.
        if ($urandom_range(0, 39) == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
